// File: hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Great-circle distance package
// Widths, fixed-point constants, and the arctangent table that the trig and
// vectoring pipelines share.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Field widths of the ports.
  localparam int unsigned LAT_W  = 28;
  localparam int unsigned LON_W  = 29;
  localparam int unsigned RAD_W  = 14;
  localparam int unsigned DIST_W = 24;

  // Default number of CORDIC iterations.
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Register map.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(3960);

  // Internal widths.
  localparam int unsigned ANG_W  = 30;  // widest angle (longitude difference)
  localparam int unsigned RED_W  = 29;  // angle reduced into one turn
  localparam int unsigned QUO_W  = 23;  // reduced angle divided by 45
  localparam int unsigned CW     = 34;  // CORDIC datapath
  localparam int unsigned COS_W  = 32;  // cosine in Q30, [-1, 1]
  localparam int unsigned HAV_W  = 31;  // value in Q30, [0, 1]
  localparam int unsigned ROOT_W = 31;  // square root result
  localparam int unsigned N_TRIG = 4;   // cosine lanes
  localparam int unsigned N_ROOT = 2;   // square-root lanes

  // Fixed-point constants.
  localparam int unsigned ONE_Q30    = 32'd1 << 30;
  localparam int unsigned HALF_PI    = 1686629713;
  localparam int unsigned GAIN       = 652032875;
  localparam int unsigned FULL_TURN  = 377487360;  // 360 degrees times 2^20
  localparam int unsigned RECIP45    = 763549742;  // ceil(2^35 / 45)
  localparam int unsigned RECIP45_SH = 35;
  localparam int unsigned REM_RECIP  = 46604;      // ceil(2^21 / 45)
  localparam int unsigned DIST_MAX   = (32'd1 << DIST_W) - 1;

  // Arctangent of 2^-i in Q30, rounded to nearest.
  localparam int AtanTab [32] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

endpackage

// File: hw/rtl/gcd_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine pipeline
// Four lanes of angle reduction, degree-to-phase conversion and an unrolled
// rotation-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module gcd_trig import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [ANG_W-1:0] ang_i [N_TRIG],
  output logic                    valid_o,
  output logic signed [COS_W-1:0] cos_o [N_TRIG]
);

  localparam int unsigned SW = ANG_W + 3;
  localparam logic signed [SW-1:0] FtS = SW'(FULL_TURN);
  localparam logic [29:0] Recip = 30'(RECIP45);
  localparam logic [15:0] RemRecip = 16'(REM_RECIP);
  localparam logic signed [31:0] HalfPiS = 32'(HALF_PI);
  localparam logic signed [CW-1:0] OneS = CW'(ONE_Q30);

  logic [4:0] vld_q;

  logic [RED_W-1:0]              red_q  [N_TRIG];
  logic [RED_W-1:0]              red2_q [N_TRIG];
  logic [QUO_W-1:0]              quo_q  [N_TRIG];
  logic [QUO_W-1:0]              quo3_q [N_TRIG];
  logic [5:0]                    rem_q  [N_TRIG];
  logic [1:0]                    quad_q [N_TRIG];
  logic signed [30:0]            res_q  [N_TRIG];

  logic [CORDIC_STEPS:0]         cv_q;
  logic signed [CW-1:0]          x_q    [CORDIC_STEPS+1][N_TRIG];
  logic signed [CW-1:0]          y_q    [CORDIC_STEPS+1][N_TRIG];
  logic signed [CW-1:0]          z_q    [CORDIC_STEPS+1][N_TRIG];
  logic [1:0]                    qd_q   [CORDIC_STEPS+1][N_TRIG];
  logic                          out_vld_q;
  logic signed [COS_W-1:0]       cos_q  [N_TRIG];

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  for (genvar l = 0; l < N_TRIG; l++) begin : g_front
    logic signed [SW-1:0] v, vp1, vp2, vm1, rsel;
    logic [RED_W+29:0]    qp;
    logic [21:0]          rm;
    logic [31:0]          phase, p2;
    logic signed [62:0]   zp;

    // Reduce the angle into one turn.
    always_comb begin
      v   = SW'(ang_i[l]);
      vp1 = v + FtS;
      vp2 = vp1 + FtS;
      vm1 = v - FtS;
      if (v < 0) begin
        rsel = (vp1 < 0) ? vp2 : vp1;
      end else begin
        rsel = (v >= FtS) ? vm1 : v;
      end
    end

    // Divide by 45 through a reciprocal, then rebuild the phase.
    always_comb begin
      qp    = RED_W'(red_q[l]) * Recip;
      rm    = rem_q[l] * RemRecip;
      phase = {quo3_q[l], 9'b0} + 32'(rm[21:12]);
      p2    = phase + 32'h2000_0000;
      zp    = res_q[l] * HalfPiS;
    end

    always_ff @(posedge clk_i) begin
      red_q[l]  <= rsel[RED_W-1:0];
      red2_q[l] <= red_q[l];
      quo_q[l]  <= qp[RECIP45_SH +: QUO_W];
      quo3_q[l] <= quo_q[l];
      rem_q[l]  <= 6'(red2_q[l] - RED_W'(quo_q[l]) * RED_W'(45));
      quad_q[l] <= p2[31:30];
      res_q[l]  <= $signed({1'b0, p2[29:0]}) - $signed(31'h2000_0000);
      // Phase residual to radians in Q30.
      x_q[0][l]  <= CW'(GAIN);
      y_q[0][l]  <= '0;
      z_q[0][l]  <= CW'(zp >>> 30);
      qd_q[0][l] <= quad_q[l];
    end
  end

  // Rotation CORDIC, one iteration per stage.
  assign cv_q[0] = vld_q[4];
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CW-1:0] At = CW'(AtanTab[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    for (genvar l = 0; l < N_TRIG; l++) begin : g_lane
      always_ff @(posedge clk_i) begin
        if (!z_q[k][l][CW-1]) begin
          x_q[k+1][l] <= x_q[k][l] - (y_q[k][l] >>> k);
          y_q[k+1][l] <= y_q[k][l] + (x_q[k][l] >>> k);
          z_q[k+1][l] <= z_q[k][l] - At;
        end else begin
          x_q[k+1][l] <= x_q[k][l] + (y_q[k][l] >>> k);
          y_q[k+1][l] <= y_q[k][l] - (x_q[k][l] >>> k);
          z_q[k+1][l] <= z_q[k][l] + At;
        end
        qd_q[k+1][l] <= qd_q[k][l];
      end
    end
  end

  // Quadrant fold and clamp to [-1, 1].
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cv_q[CORDIC_STEPS];
    end
  end

  for (genvar l = 0; l < N_TRIG; l++) begin : g_fold
    logic signed [CW-1:0] c;
    always_comb begin
      case (qd_q[CORDIC_STEPS][l])
        2'd0:    c = x_q[CORDIC_STEPS][l];
        2'd1:    c = -y_q[CORDIC_STEPS][l];
        2'd2:    c = -x_q[CORDIC_STEPS][l];
        default: c = y_q[CORDIC_STEPS][l];
      endcase
      if (c > OneS) begin
        c = OneS;
      end else if (c < -OneS) begin
        c = -OneS;
      end
    end
    always_ff @(posedge clk_i) begin
      cos_q[l] <= COS_W'(c);
    end
    assign cos_o[l] = cos_q[l];
  end

  assign valid_o = out_vld_q;

endmodule

// File: hw/rtl/gcd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-root pipeline
// Two lanes of floor(sqrt(v * 2^30)), one result bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [HAV_W-1:0]  val_i  [N_ROOT],
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o [N_ROOT]
);

  localparam int unsigned RW = 2 * ROOT_W + 1;

  logic [ROOT_W:0]   vld_q;
  logic [RW-1:0]     rem_q  [ROOT_W+1][N_ROOT];
  logic [ROOT_W-1:0] root_q [ROOT_W+1][N_ROOT];

  always_comb begin
    vld_q[0] = valid_i;
    for (int l = 0; l < N_ROOT; l++) begin
      rem_q[0][l]  = RW'({val_i[l], 30'b0});
      root_q[0][l] = '0;
    end
  end

  // Stage k settles root bit ROOT_W-1-k by a trial subtract.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int unsigned B = ROOT_W - 1 - k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    for (genvar l = 0; l < N_ROOT; l++) begin : g_lane
      logic [RW-1:0] cand;
      assign cand = (RW'(root_q[k][l]) << (B + 1)) | (RW'(1) << (2 * B));
      always_ff @(posedge clk_i) begin
        if (rem_q[k][l] >= cand) begin
          rem_q[k+1][l]  <= rem_q[k][l] - cand;
          root_q[k+1][l] <= root_q[k][l] | (ROOT_W'(1) << B);
        end else begin
          rem_q[k+1][l]  <= rem_q[k][l];
          root_q[k+1][l] <= root_q[k][l];
        end
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  for (genvar l = 0; l < N_ROOT; l++) begin : g_out
    assign root_o[l] = root_q[ROOT_W][l];
  end

endmodule

// File: hw/rtl/gcd_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arctangent pipeline
// Unrolled vectoring-mode CORDIC that turns (sqrt(1-a), sqrt(a)) into the
// half central angle, clamped to [0, pi/2].
// ----------------------------------------------------------------------------
module gcd_vec import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] x_i,
  input  logic [ROOT_W-1:0] y_i,
  output logic              valid_o,
  output logic [HAV_W-1:0]  ang_o
);

  localparam logic signed [CW-1:0] HalfPiS = CW'(HALF_PI);

  logic [CORDIC_STEPS:0] vld_q;
  logic signed [CW-1:0]  x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0]  y_q [CORDIC_STEPS+1];
  logic signed [CW-1:0]  z_q [CORDIC_STEPS+1];
  logic                  out_vld_q;
  logic [HAV_W-1:0]      ang_q;

  always_comb begin
    vld_q[0] = valid_i;
    x_q[0]   = CW'(x_i);
    y_q[0]   = CW'(y_i);
    z_q[0]   = '0;
  end

  // One vectoring iteration per stage, driving y toward zero.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CW-1:0] At = CW'(AtanTab[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_q[k][CW-1]) begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + At;
      end else begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - At;
      end
    end
  end

  // Clamp the angle to [0, pi/2].
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (z_q[CORDIC_STEPS][CW-1]) begin
      ang_q <= '0;
    end else if (z_q[CORDIC_STEPS] > HalfPiS) begin
      ang_q <= HAV_W'(HALF_PI);
    end else begin
      ang_q <= HAV_W'(z_q[CORDIC_STEPS]);
    end
  end

  assign valid_o = out_vld_q;
  assign ang_o   = ang_q;

endmodule

// File: hw/rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two points in fixed-point degrees, scaled by a
// programmable sphere radius, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Handshake
//  input     lat_a_i lon_a_i lat_b_i lon_b_i        start (busy is always low)
//  result    distance_o                             done_o, one cycle
//  config    psel penable pwrite paddr pwdata ...   APB, pready always high
//
// One item enters every cycle. The datapath runs through two CORDIC pipelines
// of one iteration per stage and a 31-stage square-root pipeline. Reset clears
// only the valid bits and loads the radius register with 3960. The result
// side cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Item input
  input  logic                    start,
  output logic                    busy,
  input  logic signed [LAT_W-1:0] lat_a_i,
  input  logic signed [LON_W-1:0] lon_a_i,
  input  logic signed [LAT_W-1:0] lat_b_i,
  input  logic signed [LON_W-1:0] lon_b_i,
  // Result output
  output logic                    done_o,
  output logic [DIST_W-1:0]       distance_o,
  // Configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic signed [HAV_W+1:0] OneS = (HAV_W+2)'(ONE_Q30);

  logic [RAD_W-1:0] radius_q;
  logic             wr_en;

  // Radius register.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS);
  assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (wr_en) begin
      radius_q <= pwdata[RAD_W-1:0];
    end
  end

  // The pipeline takes an item every cycle.
  assign busy = 1'b0;

  // Input stage: coordinate differences and the two latitudes.
  logic                    in_vld_q;
  logic signed [ANG_W-1:0] ang_q [N_TRIG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q[0] <= ANG_W'(lat_b_i) - ANG_W'(lat_a_i);
    ang_q[1] <= ANG_W'(lon_b_i) - ANG_W'(lon_a_i);
    ang_q[2] <= ANG_W'(lat_a_i);
    ang_q[3] <= ANG_W'(lat_b_i);
  end

  // Four cosines in parallel.
  logic                    cos_vld;
  logic signed [COS_W-1:0] cos_w [N_TRIG];

  gcd_trig #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_vld_q),
    .ang_i  (ang_q),
    .valid_o(cos_vld),
    .cos_o  (cos_w)
  );

  // Haversine terms and the cosine product.
  logic                    c1_vld_q, c2_vld_q, a_vld_q;
  logic [HAV_W-1:0]        hlat_q, hlon_q, hlat2_q;
  logic signed [63:0]      ccp_q, tp_q;
  logic signed [HAV_W+1:0] hlat_w, hlon_w;
  logic signed [COS_W-1:0] cc;
  logic signed [35:0]      a_sum;
  logic [HAV_W-1:0]        a_q, am_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      a_vld_q  <= 1'b0;
    end else begin
      c1_vld_q <= cos_vld;
      c2_vld_q <= c1_vld_q;
      a_vld_q  <= c2_vld_q;
    end
  end

  always_comb begin
    hlat_w = (OneS - (HAV_W+2)'(cos_w[0])) >>> 1;
    hlon_w = (OneS - (HAV_W+2)'(cos_w[1])) >>> 1;
    cc     = COS_W'(ccp_q >>> 30);
    a_sum  = 36'(hlat2_q) + 36'(tp_q >>> 30);
  end

  always_ff @(posedge clk_i) begin
    hlat_q  <= HAV_W'(hlat_w);
    hlon_q  <= HAV_W'(hlon_w);
    ccp_q   <= 64'(cos_w[2]) * 64'(cos_w[3]);
    hlat2_q <= hlat_q;
    tp_q    <= 64'(cc) * 64'($signed({1'b0, hlon_q}));
    // Saturate a to [0, 1].
    if (a_sum < 0) begin
      a_q  <= '0;
      am_q <= HAV_W'(ONE_Q30);
    end else if (a_sum > 36'(ONE_Q30)) begin
      a_q  <= HAV_W'(ONE_Q30);
      am_q <= '0;
    end else begin
      a_q  <= HAV_W'(a_sum);
      am_q <= HAV_W'(36'(ONE_Q30) - a_sum);
    end
  end

  // sqrt(1-a) and sqrt(a).
  logic              root_vld;
  logic [HAV_W-1:0]  sq_in  [N_ROOT];
  logic [ROOT_W-1:0] root_w [N_ROOT];

  assign sq_in[0] = am_q;
  assign sq_in[1] = a_q;

  gcd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(a_vld_q),
    .val_i  (sq_in),
    .valid_o(root_vld),
    .root_o (root_w)
  );

  // Half central angle.
  logic             ang_vld;
  logic [HAV_W-1:0] half_ang;

  gcd_vec #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(root_vld),
    .x_i    (root_w[0]),
    .y_i    (root_w[1]),
    .valid_o(ang_vld),
    .ang_o  (half_ang)
  );

  // Scale by the radius and round to Q8.
  logic                     p_vld_q, done_q;
  logic [RAD_W+HAV_W-1:0]   prod_q;
  logic [RAD_W+HAV_W-21:0]  dist_w;
  logic [DIST_W-1:0]        dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      p_vld_q <= ang_vld;
      done_q  <= p_vld_q;
    end
  end

  assign dist_w = (RAD_W+HAV_W-20)'((prod_q + (RAD_W+HAV_W)'(32'd1 << 20)) >> 21);

  always_ff @(posedge clk_i) begin
    prod_q <= (RAD_W+HAV_W)'(radius_q) * (RAD_W+HAV_W)'(half_ang);
    if (dist_w > (RAD_W+HAV_W-20)'(DIST_MAX)) begin
      dist_q <= DIST_W'(DIST_MAX);
    end else begin
      dist_q <= DIST_W'(dist_w);
    end
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;

  // Largest distance: the widest radius times the clamped half angle.
  localparam logic [DIST_W-1:0] DistTop =
    DIST_W'((64'((1 << RAD_W) - 1) * 64'(HALF_PI) + (64'd1 << 20)) >> 21);

  // Checks on the datapath.
  property p_dist_range;
    @(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (distance_o <= DistTop);
  endproperty
  a_dist_range: assert property (p_dist_range) else $error("distance beyond pi times radius");

  property p_a_range;
    @(posedge clk_i) disable iff (!rst_ni)
      a_vld_q |-> (a_q <= HAV_W'(ONE_Q30));
  endproperty
  a_a_range: assert property (p_a_range) else $error("haversine term not saturated");

  property p_a_pair;
    @(posedge clk_i) disable iff (!rst_ni)
      a_vld_q |-> ((32'(a_q) + 32'(am_q)) == 32'(ONE_Q30));
  endproperty
  a_a_pair: assert property (p_a_pair) else $error("a and 1-a out of step");

  property p_radius_write;
    @(posedge clk_i) disable iff (!rst_ni)
      wr_en |=> (radius_q == $past(pwdata[RAD_W-1:0]));
  endproperty
  a_radius_write: assert property (p_radius_write) else $error("radius write lost");

endmodule
